FILE: hdl/lss_pkg.sv
`default_nettype none
package lss_pkg;

    localparam int MAX_SIZE    = 8;
    localparam int VALUE_BITS  = 32;
    localparam int ROW_W       = $clog2(MAX_SIZE);
    localparam int CNT_W       = $clog2(MAX_SIZE + 1);
    localparam int STORE_DEPTH = MAX_SIZE * (MAX_SIZE + 1);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int Q_FRAC      = 16;
    localparam int SUM_W       = 50;
    localparam int NUM_W       = 48;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SINGULAR  = 2'd1;
    localparam logic [1:0] ST_SATURATED = 2'd2;

    localparam logic signed [63:0] VMAX = 64'sd2147483647;
    localparam logic signed [63:0] VMIN = -64'sd2147483648;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > VMAX)
            return VMAX[31:0];
        else if (v < VMIN)
            return VMIN[31:0];
        return v[31:0];
    endfunction

    function automatic logic ovf32(input logic signed [63:0] v);
        return (v > VMAX) || (v < VMIN);
    endfunction

    // product scaled down by 2^16, truncating toward zero
    function automatic logic signed [63:0] qtrunc(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p[63] ? (p + 64'sd65535) : p;
        return t >>> Q_FRAC;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [CNT_W-1:0] col,
                                                   input logic [CNT_W-1:0] w);
        return ADDR_W'(row) * ADDR_W'(w) + ADDR_W'(col);
    endfunction

endpackage
`default_nettype wire

FILE: hdl/lss_if.sv
`default_nettype none
interface lss_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] element_value;
    logic               is_last;

    modport source (output valid, output element_value, output is_last, input ready);
    modport sink   (input valid, input element_value, input is_last, output ready);
endinterface

interface lss_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] solution_value;
    logic [2:0]         solution_index;
    logic [1:0]         status;
    logic               end_of_run;

    modport source (output valid, output solution_value, output solution_index,
                    output status, output end_of_run, input ready);
    modport sink   (input valid, input solution_value, input solution_index,
                    input status, input end_of_run, output ready);
endinterface
`default_nettype wire

FILE: hdl/linear_system_solver.sv
// channel   dir  payload                                              transfer
// in_ch     in   element_value, is_last                               valid & ready
// out_ch    out  solution_value, solution_index, status, end_of_run   valid & ready
// cfg       in   cfg_data (size_in_use)                               cfg_we
//
// loading writes up to n(n+1) elements in order into the matrix memory; the solve then
// runs on that memory (one read port, one write port): an updated element takes a read of
// row k, a read of row i, a multiply and a write; an element of a swapped row takes two
// reads and two writes; each eliminated row and each unknown takes one divide
// results leave one per cycle when out_ch is ready; input is stalled during solve
// and output; reset returns to loading with size 8 and no clearing pass
`default_nettype none
module linear_system_solver
    import lss_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    lss_in_if.sink          in_ch,
    lss_out_if.source       out_ch,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_data
);

    localparam logic [4:0] S_LOAD     = 5'd0;
    localparam logic [4:0] S_INIT     = 5'd1;
    localparam logic [4:0] S_COL      = 5'd2;
    localparam logic [4:0] S_PIV_ISS  = 5'd3;
    localparam logic [4:0] S_PIV_CMP  = 5'd4;
    localparam logic [4:0] S_SWAP     = 5'd5;
    localparam logic [4:0] S_NEXTK    = 5'd6;
    localparam logic [4:0] S_ROW      = 5'd7;
    localparam logic [4:0] S_FDIV_GO  = 5'd8;
    localparam logic [4:0] S_FDIV     = 5'd9;
    localparam logic [4:0] S_EL_A     = 5'd10;
    localparam logic [4:0] S_EL_B     = 5'd11;
    localparam logic [4:0] S_EL_M     = 5'd12;
    localparam logic [4:0] S_EL_W     = 5'd13;
    localparam logic [4:0] S_BK_START = 5'd14;
    localparam logic [4:0] S_BK_J     = 5'd15;
    localparam logic [4:0] S_BK_M     = 5'd16;
    localparam logic [4:0] S_BK_ACC   = 5'd17;
    localparam logic [4:0] S_BK_RHS   = 5'd18;
    localparam logic [4:0] S_BK_DIAG  = 5'd19;
    localparam logic [4:0] S_BK_DIV   = 5'd20;
    localparam logic [4:0] S_BK_NEXT  = 5'd21;
    localparam logic [4:0] S_OUT      = 5'd22;
    localparam logic [4:0] S_SW_RK    = 5'd23;
    localparam logic [4:0] S_SW_RB    = 5'd24;
    localparam logic [4:0] S_SW_WK    = 5'd25;
    localparam logic [4:0] S_SW_WB    = 5'd26;
    localparam logic [4:0] S_PIVOT    = 5'd27;

    logic [4:0]               state_reg, state_next;
    logic [3:0]               n_reg;
    logic [ADDR_W-1:0]        load_pos_reg, load_pos_next;
    logic [CNT_W-1:0]         k_reg, k_next, i_reg, i_next, j_reg, j_next;
    logic [ROW_W-1:0]         best_reg, best_next;
    logic [31:0]              best_abs_reg, best_abs_next;
    logic signed [31:0]       best_val_reg, best_val_next;
    logic signed [31:0]       f_reg, f_next;
    logic signed [31:0]       akj_reg, akj_next;
    logic signed [31:0]       aij_reg, aij_next;
    logic signed [63:0]       prod_reg, prod_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [NUM_W-1:0]  num_reg, num_next;
    logic [1:0]               flags_reg, flags_next;
    logic signed [31:0]       x_reg [MAX_SIZE];
    logic signed [31:0]       x_next [MAX_SIZE];

    logic [CNT_W-1:0]         n_eff, w_eff;
    logic [ADDR_W-1:0]        slots;
    logic [ROW_W-1:0]         row_i;
    logic [ROW_W-1:0]         row_k;
    logic [ROW_W-1:0]         x_idx;
    logic signed [31:0]       x_sel;
    logic signed [31:0]       rd;
    logic [31:0]              mag;
    logic signed [63:0]       diff;
    logic signed [SUM_W:0]    num_full;
    logic signed [63:0]       q_wide;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
    logic [31:0]              ram_wdata, ram_rdata;
    logic                     div_start, div_busy, div_done;
    logic signed [63:0]       div_dividend, div_quot;
    logic signed [31:0]       div_divisor;

    lss_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_matrix (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign n_eff  = (n_reg == 4'd0) ? CNT_W'(1) :
                    (n_reg > 4'(MAX_SIZE)) ? CNT_W'(MAX_SIZE) : CNT_W'(n_reg);
    assign w_eff  = n_eff + CNT_W'(1);
    assign slots  = ADDR_W'(n_eff) * ADDR_W'(w_eff);
    assign row_i  = i_reg[ROW_W-1:0];
    assign row_k  = k_reg[ROW_W-1:0];
    assign x_idx  = (state_reg == S_OUT) ? i_reg[ROW_W-1:0] : j_reg[ROW_W-1:0];
    assign x_sel  = x_reg[x_idx];
    assign rd     = $signed(ram_rdata);
    assign mag    = rd[31] ? (~ram_rdata + 32'd1) : ram_rdata;
    assign q_wide = div_quot;

    always_comb
    begin
        state_next     = state_reg;
        load_pos_next  = load_pos_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        best_next      = best_reg;
        best_abs_next  = best_abs_reg;
        best_val_next  = best_val_reg;
        f_next         = f_reg;
        akj_next       = akj_reg;
        aij_next       = aij_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        num_next       = num_reg;
        flags_next     = flags_reg;
        x_next         = x_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;
        diff           = '0;
        num_full       = '0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_ch.valid)
                begin
                    if (load_pos_reg < slots)
                    begin
                        ram_we        = 1'b1;
                        ram_waddr     = load_pos_reg;
                        ram_wdata     = in_ch.element_value;
                        load_pos_next = load_pos_reg + ADDR_W'(1);
                    end
                    if (in_ch.is_last)
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                flags_next    = 2'b00;
                load_pos_next = '0;
                k_next        = '0;
                state_next    = S_COL;
            end
            S_COL:
            begin
                i_next     = k_reg;
                state_next = S_PIV_ISS;
            end
            S_PIV_ISS:
            begin
                ram_raddr  = cell_addr(row_i, k_reg, w_eff);
                state_next = S_PIV_CMP;
            end
            S_PIV_CMP:
            begin
                if ((i_reg == k_reg) || (best_abs_reg < mag))
                begin
                    best_next     = row_i;
                    best_abs_next = mag;
                    best_val_next = rd;
                end
                i_next     = i_reg + CNT_W'(1);
                state_next = ((i_reg + CNT_W'(1)) < n_eff) ? S_PIV_ISS : S_SWAP;
            end
            S_SWAP:
            begin
                j_next     = '0;
                state_next = (best_reg != row_k) ? S_SW_RK : S_PIVOT;
            end
            // exchange pivot row and row k in memory
            S_SW_RK:
            begin
                ram_raddr  = cell_addr(row_k, j_reg, w_eff);
                state_next = S_SW_RB;
            end
            S_SW_RB:
            begin
                akj_next   = rd;
                ram_raddr  = cell_addr(best_reg, j_reg, w_eff);
                state_next = S_SW_WK;
            end
            S_SW_WK:
            begin
                ram_we     = 1'b1;
                ram_waddr  = cell_addr(row_k, j_reg, w_eff);
                ram_wdata  = rd;
                state_next = S_SW_WB;
            end
            S_SW_WB:
            begin
                ram_we     = 1'b1;
                ram_waddr  = cell_addr(best_reg, j_reg, w_eff);
                ram_wdata  = akj_reg;
                j_next     = j_reg + CNT_W'(1);
                state_next = (j_reg < n_eff) ? S_SW_RK : S_PIVOT;
            end
            S_PIVOT:
            begin
                if (best_val_reg == 32'sd0)
                begin
                    flags_next[0] = 1'b1;
                    state_next    = S_NEXTK;
                end
                else
                begin
                    i_next     = k_reg + CNT_W'(1);
                    state_next = S_ROW;
                end
            end
            S_NEXTK:
            begin
                k_next = k_reg + CNT_W'(1);
                if ((k_reg + CNT_W'(1)) < n_eff)
                begin
                    state_next = S_COL;
                end
                else
                begin
                    i_next     = n_eff - CNT_W'(1);
                    state_next = S_BK_START;
                end
            end
            S_ROW:
            begin
                if (i_reg >= n_eff)
                begin
                    state_next = S_NEXTK;
                end
                else
                begin
                    ram_raddr  = cell_addr(row_i, k_reg, w_eff);
                    state_next = S_FDIV_GO;
                end
            end
            S_FDIV_GO:
            begin
                div_start    = 1'b1;
                div_dividend = 64'(rd) <<< Q_FRAC;
                div_divisor  = best_val_reg;
                j_next       = k_reg;
                state_next   = S_FDIV;
            end
            S_FDIV:
            begin
                if (div_done)
                begin
                    f_next        = sat32(q_wide);
                    flags_next[1] = flags_reg[1] | ovf32(q_wide);
                    state_next    = S_EL_A;
                end
            end
            S_EL_A:
            begin
                ram_raddr  = cell_addr(row_k, j_reg, w_eff);
                state_next = S_EL_B;
            end
            S_EL_B:
            begin
                akj_next   = rd;
                ram_raddr  = cell_addr(row_i, j_reg, w_eff);
                state_next = S_EL_M;
            end
            S_EL_M:
            begin
                aij_next   = rd;
                prod_next  = 64'(f_reg) * 64'(akj_reg);
                state_next = S_EL_W;
            end
            S_EL_W:
            begin
                diff          = 64'(aij_reg) - qtrunc(prod_reg);
                ram_we        = 1'b1;
                ram_waddr     = cell_addr(row_i, j_reg, w_eff);
                ram_wdata     = sat32(diff);
                flags_next[1] = flags_reg[1] | ovf32(diff);
                j_next        = j_reg + CNT_W'(1);
                if (j_reg < n_eff)
                begin
                    state_next = S_EL_A;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_ROW;
                end
            end
            S_BK_START:
            begin
                sum_next   = '0;
                j_next     = i_reg + CNT_W'(1);
                state_next = S_BK_J;
            end
            S_BK_J:
            begin
                if (j_reg < n_eff)
                begin
                    ram_raddr  = cell_addr(row_i, j_reg, w_eff);
                    state_next = S_BK_M;
                end
                else
                begin
                    ram_raddr  = cell_addr(row_i, n_eff, w_eff);
                    state_next = S_BK_RHS;
                end
            end
            S_BK_M:
            begin
                prod_next  = 64'(rd) * 64'(x_sel);
                state_next = S_BK_ACC;
            end
            S_BK_ACC:
            begin
                sum_next   = sum_reg + SUM_W'(qtrunc(prod_reg));
                j_next     = j_reg + CNT_W'(1);
                state_next = S_BK_J;
            end
            S_BK_RHS:
            begin
                num_full = (SUM_W+1)'(rd) - (SUM_W+1)'(sum_reg);
                if (num_full > (SUM_W+1)'(64'sd1 <<< 46))
                begin
                    num_next      = NUM_W'(64'sd1 <<< 46);
                    flags_next[1] = 1'b1;
                end
                else if (num_full < -((SUM_W+1)'(64'sd1 <<< 46)))
                begin
                    num_next      = -NUM_W'(64'sd1 <<< 46);
                    flags_next[1] = 1'b1;
                end
                else
                begin
                    num_next = NUM_W'(num_full);
                end
                ram_raddr  = cell_addr(row_i, i_reg, w_eff);
                state_next = S_BK_DIAG;
            end
            S_BK_DIAG:
            begin
                if (rd == 32'sd0)
                begin
                    flags_next[0]               = 1'b1;
                    x_next[i_reg[ROW_W-1:0]]    = '0;
                    state_next                  = S_BK_NEXT;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = 64'(num_reg) <<< Q_FRAC;
                    div_divisor  = rd;
                    state_next   = S_BK_DIV;
                end
            end
            S_BK_DIV:
            begin
                if (div_done)
                begin
                    x_next[i_reg[ROW_W-1:0]] = sat32(q_wide);
                    flags_next[1]            = flags_reg[1] | ovf32(q_wide);
                    state_next               = S_BK_NEXT;
                end
            end
            S_BK_NEXT:
            begin
                if (i_reg == '0)
                begin
                    i_next     = n_eff - CNT_W'(1);
                    state_next = S_OUT;
                end
                else
                begin
                    i_next     = i_reg - CNT_W'(1);
                    state_next = S_BK_START;
                end
            end
            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    if (i_reg == '0)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        i_next = i_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            n_reg        <= 4'(MAX_SIZE);
            load_pos_reg <= '0;
            flags_reg    <= 2'b00;
            k_reg        <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_pos_reg <= load_pos_next;
            flags_reg    <= flags_next;
            k_reg        <= k_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            if (cfg_we)
            begin
                n_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg      <= best_next;
        best_abs_reg  <= best_abs_next;
        best_val_reg  <= best_val_next;
        f_reg         <= f_next;
        akj_reg       <= akj_next;
        aij_reg       <= aij_next;
        prod_reg      <= prod_next;
        sum_reg       <= sum_next;
        num_reg       <= num_next;
        x_reg         <= x_next;
    end

    assign in_ch.ready           = (state_reg == S_LOAD);
    assign out_ch.valid          = (state_reg == S_OUT);
    assign out_ch.solution_value = x_sel;
    assign out_ch.solution_index = 3'(i_reg);
    assign out_ch.status         = flags_reg[0] ? ST_SINGULAR :
                                   (flags_reg[1] ? ST_SATURATED : ST_OK);
    assign out_ch.end_of_run     = (i_reg == '0);

    a_in_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("input and output open together");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_ram_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ram_waddr < ADDR_W'(STORE_DEPTH)))
        else $error("matrix write out of range");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.end_of_run) |=> in_ch.ready)
        else $error("no return to loading after final result");

    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_FDIV || state_reg == S_BK_DIV))
        else $error("quotient arrived outside a divide wait");

endmodule
`default_nettype wire

FILE: hdl/lss_ram.sv
`default_nettype none
module lss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 72
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: hdl/lss_div.sv
`default_nettype none
module lss_div
    import lss_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [63:0] dividend,
    input  wire logic signed [31:0] divisor,
    output logic                    busy,
    output logic                    done,
    output logic signed [63:0]      quotient
);

    logic [63:0] acc_reg,  acc_next;
    logic [32:0] rem_reg,  rem_next;
    logic [31:0] dvs_reg,  dvs_next;
    logic        neg_reg,  neg_next;
    logic [6:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] rem_sh;

    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[31:0], acc_reg[63]};
        if (start)
        begin
            acc_next  = dividend[63] ? 64'(-dividend) : 64'(dividend);
            dvs_next  = divisor[31] ? (~divisor + 32'd1) : divisor;
            neg_next  = dividend[63] ^ divisor[31];
            rem_next  = '0;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                acc_next = {acc_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                acc_next = {acc_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);

endmodule
`default_nettype wire
